>>> design/pfla_pkg.sv
// pfla_pkg: shared types and codes for the pool free-list allocator
// holds request/response payload structs, request kind codes and fsm states
// no dependencies
package pfla_pkg;

    localparam int POOL_ENTRIES_DEF = 256;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] block_index;
    } t_req;

    typedef struct packed {
        logic [7:0] granted_index;
        logic       ok;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC
    } t_state;

endpackage

>>> design/pool_free_list_allocator.sv
// pool_free_list_allocator: lifo free list of fixed-size blocks
// link store in a one-port-write, one-port-read synchronous memory plus head register
// depends on pfla_pkg
//
// One request transaction in, one response transaction out. A free, an
// allocate on an empty pool and an undefined kind are answered from the idle
// state; an allocate first passes through ST_ALLOC, since the link of the head
// block comes out of the registered read port of the link memory. After reset,
// and after every pool-reset request, the link memory is rebuilt by a sweep
// over every entry, one entry per cycle, during which no request is accepted;
// the pool-reset response does not wait for the sweep. Responses are registered,
// so in idle a request is taken in the same cycle the previous response is taken.
module pool_free_list_allocator #(
    parameter int POOL_ENTRIES = pfla_pkg::POOL_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfla_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pfla_pkg::t_rsp o_out_data
);
    import pfla_pkg::*;

    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam logic [LW-1:0] END_MARK  = LW'(POOL_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_ENTRIES - 1);

    logic [LW-1:0] mem_link [POOL_ENTRIES];

    t_state        r_state, n_state;
    logic [LW-1:0] r_head, n_head;
    logic          r_nonempty, n_nonempty;
    logic [AW-1:0] r_sweep, n_sweep;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out_data, n_out_data;
    logic [LW-1:0] r_link_q;

    logic          w_we;
    logic          w_re;
    logic [AW-1:0] w_waddr;
    logic [LW-1:0] w_wdata;
    logic          w_slot;
    logic          w_idx_ok;

    assign w_slot   = !r_out_valid || i_out_ready;
    assign w_idx_ok = (32'(i_in_data.block_index) < 32'(POOL_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_link[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_link_q <= mem_link[r_head[AW-1:0]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_nonempty  = r_nonempty;
        n_sweep     = r_sweep;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = r_sweep;
        w_wdata     = LW'(r_sweep) + LW'(1);
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_sweep = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            ST_IDLE: begin
                o_in_ready = w_slot;
                if (i_in_valid && w_slot) begin
                    n_out_data = '{granted_index: 8'd0, ok: 1'b0};
                    case (i_in_data.kind)
                        KIND_ALLOC: begin
                            if (r_nonempty && r_head < END_MARK) begin
                                w_re    = 1'b1;
                                n_state = ST_ALLOC;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        KIND_FREE: begin
                            n_out_valid = 1'b1;
                            if (w_idx_ok) begin
                                w_we          = 1'b1;
                                w_waddr       = AW'(i_in_data.block_index);
                                w_wdata       = r_nonempty ? r_head : END_MARK;
                                n_head        = LW'(i_in_data.block_index);
                                n_nonempty    = 1'b1;
                                n_out_data.ok = 1'b1;
                            end
                        end
                        KIND_RESET: begin
                            n_out_valid   = 1'b1;
                            n_out_data.ok = 1'b1;
                            n_head        = '0;
                            n_nonempty    = 1'b1;
                            n_sweep       = '0;
                            n_state       = ST_CLEAR;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{granted_index: 8'(r_head), ok: 1'b1};
                    n_state     = ST_IDLE;
                    if (r_link_q >= END_MARK) begin
                        n_nonempty = 1'b0;
                        n_head     = '0;
                    end else begin
                        n_head = r_link_q;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_head      <= '0;
            r_nonempty  <= 1'b1;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> design/pfla_checker.sv
// pfla_checker: port-level assertions for pool_free_list_allocator
// bound to the top level below; depends on pfla_pkg
module pfla_checker #(
    parameter int POOL_ENTRIES = pfla_pkg::POOL_ENTRIES_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input pfla_pkg::t_req i_in_data,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input pfla_pkg::t_rsp i_out_data
);
    import pfla_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // held response stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("response changed while stalled");

    // rebuild sweep follows reset
    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request accepted right after reset");

    a_pool_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_data.kind == KIND_RESET
        |=> i_out_valid && i_out_data.ok && !i_in_ready)
        else $error("pool reset transaction mishandled");

    a_free_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_data.kind == KIND_FREE
        && (32'(i_in_data.block_index) < 32'(POOL_ENTRIES))
        |=> i_out_valid && i_out_data.ok && i_out_data.granted_index == 8'd0)
        else $error("valid free transaction not acknowledged");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.ok |-> i_out_data.granted_index == 8'd0)
        else $error("failed transaction carries nonzero index");

endmodule

bind pool_free_list_allocator pfla_checker #(.POOL_ENTRIES(POOL_ENTRIES)) u_pfla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
